>>> sv/mvga_pkg.sv
// mvga_pkg: shared types and constants of the mesh volume gradient accumulator
// no dependencies; used by mvga_cross and mesh_volume_gradient_accumulator_core
package mvga_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned GRAD_W = 64;
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned NRM_W  = PROD_W + 1;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FACE  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IDX_W-1:0]        idx_a;
    logic [IDX_W-1:0]        idx_b;
    logic [IDX_W-1:0]        idx_c;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]         vertex_index;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic                     saturated;
  } out_word_t;

  // one vertex position
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } vec_t;

  // area normal, signed, with twice the fraction bits of a position
  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } nrm_t;

  // one row of the gradient memory
  typedef struct packed {
    logic [GRAD_W-1:0] x;
    logic [GRAD_W-1:0] y;
    logic [GRAD_W-1:0] z;
    logic              sat;
  } grad_row_t;

endpackage

>>> sv/mvga_cross.sv
// mvga_cross: three-stage area normal pipeline (differences, products, cross)
// depends on mvga_pkg
module mvga_cross (
  input  logic           clk_i,
  input  logic           en_i,
  input  mvga_pkg::vec_t pos_a_i,
  input  mvga_pkg::vec_t pos_b_i,
  input  mvga_pkg::vec_t pos_c_i,
  output mvga_pkg::nrm_t normal_o
);
  import mvga_pkg::*;

  logic signed [DIFF_W-1:0] ux_d, uy_d, uz_d, wx_d, wy_d, wz_d;
  logic signed [DIFF_W-1:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  logic signed [PROD_W-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  nrm_t                     nrm_q;

  // u = a - c, w = b - c, sign-extended by one bit
  assign ux_d = {pos_a_i.x[POS_W-1], pos_a_i.x} - {pos_c_i.x[POS_W-1], pos_c_i.x};
  assign uy_d = {pos_a_i.y[POS_W-1], pos_a_i.y} - {pos_c_i.y[POS_W-1], pos_c_i.y};
  assign uz_d = {pos_a_i.z[POS_W-1], pos_a_i.z} - {pos_c_i.z[POS_W-1], pos_c_i.z};
  assign wx_d = {pos_b_i.x[POS_W-1], pos_b_i.x} - {pos_c_i.x[POS_W-1], pos_c_i.x};
  assign wy_d = {pos_b_i.y[POS_W-1], pos_b_i.y} - {pos_c_i.y[POS_W-1], pos_c_i.y};
  assign wz_d = {pos_b_i.z[POS_W-1], pos_b_i.z} - {pos_c_i.z[POS_W-1], pos_c_i.z};

  // stages advance together, and only while the caller holds en_i high
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q  <= ux_d;
      uy_q  <= uy_d;
      uz_q  <= uz_d;
      wx_q  <= wx_d;
      wy_q  <= wy_d;
      wz_q  <= wz_d;
      p0_q  <= uy_q * wz_q;
      p1_q  <= uz_q * wy_q;
      p2_q  <= uz_q * wx_q;
      p3_q  <= ux_q * wz_q;
      p4_q  <= ux_q * wy_q;
      p5_q  <= uy_q * wx_q;
      nrm_q.x <= NRM_W'(p0_q) - NRM_W'(p1_q);
      nrm_q.y <= NRM_W'(p2_q) - NRM_W'(p3_q);
      nrm_q.z <= NRM_W'(p4_q) - NRM_W'(p5_q);
    end
  end

  assign normal_o = nrm_q;

endmodule

>>> sv/mesh_volume_gradient_accumulator_core.sv
// mesh volume gradient accumulator: vertex position memory, per-vertex gradient
// memory with saturating read-modify-write, one word in and at most one word out
// a load or clear writes its memory when the word is taken; a read goes through the
//   gradient read register to the output register; a face does three position reads,
//   three normal stages and three gradient updates on the single gradient port pair
// reset: rst_ni clears control state, then a sweep zeroes every gradient memory row
//   while the input stays stalled; positions are undefined until loaded
module mesh_volume_gradient_accumulator_core #(
  parameter int unsigned MAX_VERTICES = mvga_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mvga_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mvga_pkg::out_word_t out_word_o
);
  import mvga_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  // one-hot sequencer
  typedef enum logic [8:0] {
    ST_INIT = 9'b000000001,  // zeroing sweep after reset
    ST_IDLE = 9'b000000010,
    ST_PA   = 9'b000000100,  // position a arrives
    ST_PB   = 9'b000001000,  // position b arrives
    ST_PC   = 9'b000010000,  // position c arrives, differences taken
    ST_MUL  = 9'b000100000,
    ST_CRS  = 9'b001000000,  // normal formed, gradient of a requested
    ST_ACC  = 9'b010000000,  // gradient update of a, b, c in turn
    ST_RD   = 9'b100000000   // gradient word arrives for a read
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_ptr_q;
  logic [1:0]        acc_cnt_q;
  logic [AW-1:0]     addr_a_q, addr_b_q, addr_c_q;
  logic [IDX_W-1:0]  vtx_q;
  logic              rd_ok_q;
  vec_t              pos_a_q, pos_b_q;
  logic              fwd_valid_q;
  logic [AW-1:0]     fwd_addr_q;
  grad_row_t         fwd_data_q;
  logic              out_valid_q;
  out_word_t         out_word_q;

  // memories
  vec_t              pos_mem [MAX_VERTICES];
  grad_row_t         grad_mem [MAX_VERTICES];
  vec_t              pos_rdata_q;
  grad_row_t         grad_rdata_q;

  logic              pos_we;
  logic [AW-1:0]     pos_waddr, pos_raddr;
  vec_t              pos_wdata;
  logic              grad_we;
  logic [AW-1:0]     grad_waddr, grad_raddr;
  grad_row_t         grad_wdata;

  logic              in_take;
  logic              ok_a, ok_b, ok_c;
  logic [AW-1:0]     in_addr_a, in_addr_b, in_addr_c;
  logic [AW-1:0]     acc_addr;
  grad_row_t         grad_old, grad_new;
  nrm_t              normal;
  logic              cross_en;
  logic [GRAD_W:0]   add_x, add_y, add_z;

  // saturating add of the sign-extended normal; top bit flags a clamp
  function automatic logic [GRAD_W:0] sat_add(logic [GRAD_W-1:0] acc,
                                              logic signed [NRM_W-1:0] inc);
    logic [GRAD_W-1:0] b;
    logic [GRAD_W-1:0] s;
    logic              ovf;
    b   = GRAD_W'(inc);
    s   = acc + b;
    ovf = (acc[GRAD_W-1] == b[GRAD_W-1]) && (s[GRAD_W-1] != acc[GRAD_W-1]);
    if (ovf) begin
      s = acc[GRAD_W-1] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
    end
    return {ovf, s};
  endfunction

  // handshake: words are taken only when idle, and held off while a result waits
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_take    = in_valid_i && !in_stall_o;

  // index range checks and memory addresses
  assign ok_a      = 32'(in_word_i.idx_a) < 32'(MAX_VERTICES);
  assign ok_b      = 32'(in_word_i.idx_b) < 32'(MAX_VERTICES);
  assign ok_c      = 32'(in_word_i.idx_c) < 32'(MAX_VERTICES);
  assign in_addr_a = AW'(in_word_i.idx_a);
  assign in_addr_b = AW'(in_word_i.idx_b);
  assign in_addr_c = AW'(in_word_i.idx_c);

  // vertex being updated in the accumulate phase
  always_comb begin
    case (acc_cnt_q)
      2'd0:    acc_addr = addr_a_q;
      2'd1:    acc_addr = addr_b_q;
      default: acc_addr = addr_c_q;
    endcase
  end

  // the previous cycle's write is not yet visible in the read data when a
  // face repeats an index, so take it from the bypass register instead
  assign grad_old = (fwd_valid_q && (fwd_addr_q == acc_addr)) ? fwd_data_q : grad_rdata_q;

  assign add_x = sat_add(grad_old.x, normal.x);
  assign add_y = sat_add(grad_old.y, normal.y);
  assign add_z = sat_add(grad_old.z, normal.z);

  always_comb begin
    grad_new.x   = add_x[GRAD_W-1:0];
    grad_new.y   = add_y[GRAD_W-1:0];
    grad_new.z   = add_z[GRAD_W-1:0];
    grad_new.sat = grad_old.sat | add_x[GRAD_W] | add_y[GRAD_W] | add_z[GRAD_W];
  end

  // position memory port control
  always_comb begin
    pos_we      = in_take && (in_word_i.req_type == REQ_LOAD) && ok_a;
    pos_waddr   = in_addr_a;
    pos_wdata.x = in_word_i.pos_x;
    pos_wdata.y = in_word_i.pos_y;
    pos_wdata.z = in_word_i.pos_z;
    case (state_q)
      ST_IDLE: pos_raddr = in_addr_a;
      ST_PA:   pos_raddr = addr_b_q;
      ST_PB:   pos_raddr = addr_c_q;
      default: pos_raddr = addr_a_q;
    endcase
  end

  // gradient memory port control
  always_comb begin
    grad_we    = 1'b0;
    grad_waddr = acc_addr;
    grad_wdata = grad_new;
    grad_raddr = addr_a_q;
    case (state_q)
      ST_INIT: begin
        grad_we    = 1'b1;
        grad_waddr = clr_ptr_q;
        grad_wdata = '0;
      end
      ST_IDLE: begin
        grad_raddr = in_addr_a;
        grad_we    = in_take && (in_word_i.req_type == REQ_CLEAR) && ok_a;
        grad_waddr = in_addr_a;
        grad_wdata = '0;
      end
      ST_CRS: begin
        grad_raddr = addr_a_q;
      end
      ST_ACC: begin
        grad_we    = 1'b1;
        grad_raddr = (acc_cnt_q == 2'd0) ? addr_b_q : addr_c_q;
      end
      default: begin
        grad_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rdata_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (grad_we) begin
      grad_mem[grad_waddr] <= grad_wdata;
    end
    grad_rdata_q <= grad_mem[grad_raddr];
  end

  // normal pipeline is enabled in ST_PC, ST_MUL and ST_CRS, from the state in which position c arrives
  assign cross_en = (state_q == ST_PC) || (state_q == ST_MUL) || (state_q == ST_CRS);

  mvga_cross u_cross (
    .clk_i    (clk_i),
    .en_i     (cross_en),
    .pos_a_i  (pos_a_q),
    .pos_b_i  (pos_b_q),
    .pos_c_i  (pos_rdata_q),
    .normal_o (normal)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (clr_ptr_q == AW'(MAX_VERTICES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_take) begin
          case (in_word_i.req_type)
            REQ_FACE: if (ok_a && ok_b && ok_c) state_d = ST_PA;
            REQ_READ: state_d = ST_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_PA:  state_d = ST_PB;
      ST_PB:  state_d = ST_PC;
      ST_PC:  state_d = ST_MUL;
      ST_MUL: state_d = ST_CRS;
      ST_CRS: state_d = ST_ACC;
      ST_ACC: begin
        if (acc_cnt_q == 2'd2) state_d = ST_IDLE;
      end
      ST_RD:   state_d = ST_IDLE;
      default: state_d = ST_INIT;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_ptr_q   <= '0;
      acc_cnt_q   <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fwd_valid_q <= (state_q == ST_ACC);
      if (state_q == ST_INIT) begin
        clr_ptr_q <= clr_ptr_q + 1'b1;
      end
      if (state_q == ST_ACC) begin
        acc_cnt_q <= acc_cnt_q + 2'd1;
      end else begin
        acc_cnt_q <= '0;
      end
      if (state_q == ST_RD) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      addr_a_q <= in_addr_a;
      addr_b_q <= in_addr_b;
      addr_c_q <= in_addr_c;
      vtx_q    <= in_word_i.idx_a;
      rd_ok_q  <= ok_a;
    end
    if (state_q == ST_PA) begin
      pos_a_q <= pos_rdata_q;
    end
    if (state_q == ST_PB) begin
      pos_b_q <= pos_rdata_q;
    end
    fwd_addr_q <= acc_addr;
    fwd_data_q <= grad_new;
    if (state_q == ST_RD) begin
      // an out-of-range read returns zeros
      out_word_q.vertex_index <= vtx_q;
      out_word_q.grad_x       <= rd_ok_q ? grad_rdata_q.x : '0;
      out_word_q.grad_y       <= rd_ok_q ? grad_rdata_q.y : '0;
      out_word_q.grad_z       <= rd_ok_q ? grad_rdata_q.z : '0;
      out_word_q.saturated    <= rd_ok_q & grad_rdata_q.sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
